### sv/rcca_pkg.sv
// ----------------------------------------------------------------------------
// rcca_pkg
// Shared types and constants for the RC channel conditioner and arming core.
// ----------------------------------------------------------------------------
package rcca_pkg;

   localparam int CHANNELS   = 8;
   localparam int CHAN_IDX_W = $clog2(CHANNELS);

   // serial divider geometry
   localparam int DIVIDEND_W = 23;
   localparam int DIVISOR_W  = 12;
   localparam int DIV_CNT_W  = 5;

   // configuration register indexes
   localparam logic [2:0] CSR_FILTER_GAIN  = 3'd0;
   localparam logic [2:0] CSR_TICK_MS      = 3'd1;
   localparam logic [2:0] CSR_MIN_STICK    = 3'd2;
   localparam logic [2:0] CSR_MAX_STICK    = 3'd3;
   localparam logic [2:0] CSR_REVERSE_MASK = 3'd4;

   // link modes
   localparam logic [1:0] MODE_LOST   = 2'd0;
   localparam logic [1:0] MODE_RADIO  = 2'd1;
   localparam logic [1:0] MODE_GROUND = 2'd2;
   localparam logic [1:0] MODE_MIXED  = 2'd3;

   // operations
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FEED   = 1'b1;

   localparam logic [15:0]        ARM_DONE     = 16'hFFFF;
   localparam logic signed [17:0] FILT_ARM_LO  = -18'sd102400;
   localparam logic signed [17:0] FILT_ARM_HI  = 18'sd102400;
   localparam logic signed [17:0] FILT_FORCED  = -18'sd128000;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_NUM, S_DIV, S_FSETUP, S_MUL, S_FILT, S_DONE
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

### sv/rcca_div.sv
// ----------------------------------------------------------------------------
// rcca_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcca_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rcca_pkg::div_req_type div_req,
   output rcca_pkg::div_rsp_type div_rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [rcca_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [rcca_pkg::DIVIDEND_W-1:0]     quo_ff, quo_in;
   logic [rcca_pkg::DIVISOR_W-1:0]      rem_ff, rem_in;
   logic [rcca_pkg::DIVISOR_W-1:0]      den_ff, den_in;
   logic [rcca_pkg::DIVISOR_W:0]        shifted;
   logic [rcca_pkg::DIVISOR_W:0]        trial;

   // shift one dividend bit into the remainder and try a subtract
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quo_ff[rcca_pkg::DIVIDEND_W-1]};
      trial   = shifted - {1'b0, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[rcca_pkg::DIVISOR_W]) begin
            rem_in = trial[rcca_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[rcca_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[rcca_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[rcca_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rcca_pkg::DIV_CNT_W'(rcca_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider restarted while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider busy after done");

endmodule

### sv/rc_channel_conditioner_arming_core.sv
// ----------------------------------------------------------------------------
// rc_channel_conditioner_arming_core
// Conditions one RC channel per sample item: source select, range check, stick
// normalization, adaptive Q.8 filter, frame-end arming and link watchdog; feed items update the link mode.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid/req_ready   | operation, channel, samples, frame, mode
//  rsp_    | out       | rsp_valid/rsp_ready   | channel, stick, filter, status flags
//  csr_    | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
//  A normalized sample passes the divide step (23 quotient bits, one per cycle)
//  and then the bit-serial filter multiplier over the 16 gain bits. Without
//  normalization the divide step is skipped, and a feed item goes straight to
//  the finish step. One item is worked at a time.
//  Reset is synchronous; it restores all channel, block and configuration state.
//  The result sits in an output register; the next item is taken while it
//  waits, and a stalled result only holds the block at its final step.
// ----------------------------------------------------------------------------
module rc_channel_conditioner_arming_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [2:0]         req_channel,
   input  logic [11:0]        req_rc_sample,
   input  logic [11:0]        req_gs_sample,
   input  logic               req_last_in_frame,
   input  logic [1:0]         req_feed_mode,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_channel_out,
   output logic signed [9:0]  rsp_stick_value,
   output logic signed [17:0] rsp_filtered_value,
   output logic signed [18:0] rsp_filtered_change,
   output logic               rsp_channel_fault,
   output logic               rsp_armed,
   output logic [1:0]         rsp_link_mode,
   output logic               rsp_link_lost,
   output logic               rsp_calibrate_request,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int CH = rcca_pkg::CHANNELS;

   // configuration
   logic [15:0] gain_ff;
   logic [6:0]  tick_ff;
   logic [11:0] min_ff, max_ff;
   logic [7:0]  rev_ff;

   // block state
   rcca_pkg::state_type state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  link_ff, link_in;
   logic        arm_ff, arm_in;
   logic [15:0] armt_ff, armt_in;
   logic [11:0]        held_ff [CH], held_in [CH];
   logic               fault_ff[CH], fault_in[CH];
   logic [10:0]        good_ff [CH], good_in [CH];
   logic signed [9:0]  norm_ff [CH], norm_in [CH];
   logic signed [17:0] filt_ff [CH], filt_in [CH];
   logic signed [17:0] prev_ff [CH], prev_in [CH];
   logic [11:0]        raw_ff  [4],  raw_in  [4];

   // item in work
   logic        op_ff, op_in;
   logic [2:0]  chan_ff, chan_in;
   logic [11:0] rc_ff, rc_in, gs_ff, gs_in;
   logic        last_ff, last_in;
   logic [1:0]  fm_ff, fm_in;
   logic [11:0] s_ff, s_in;
   logic        neg_ff, neg_in;
   logic        wide_ff, wide_in;
   logic signed [34:0] mcand_ff, mcand_in, acc_ff, acc_in;
   logic [15:0] mplier_ff, mplier_in;
   logic [3:0]  mcnt_ff, mcnt_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         o_chan_ff, o_chan_in;
   logic signed [9:0]  o_stick_ff, o_stick_in;
   logic signed [17:0] o_fv_ff, o_fv_in;
   logic signed [18:0] o_chg_ff, o_chg_in;
   logic               o_fault_ff, o_fault_in;
   logic               o_arm_ff, o_arm_in;
   logic [1:0]         o_mode_ff, o_mode_in;
   logic               o_cal_ff, o_cal_in;

   // temporaries
   logic [rcca_pkg::CHAN_IDX_W-1:0] idx;
   logic        chan_ok;
   logic [11:0] samp;
   logic [10:0] good_next;
   logic        fault_new;
   logic signed [12:0] num_a;
   logic signed [24:0] num, num_mag;
   logic [9:0]  qmag;
   logic signed [9:0]  qval;
   logic signed [18:0] err;
   logic signed [21:0] diff, diff_mag;
   logic signed [34:0] step, fsum;
   logic        fe_arm, fe_cal;
   logic [1:0]  fe_mode;
   logic [15:0] fe_t;
   logic [16:0] tsum;
   logic [8:0]  lnext;

   rcca_pkg::div_req_type div_req;
   rcca_pkg::div_rsp_type div_rsp;

   rcca_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign idx       = rcca_pkg::CHAN_IDX_W'(chan_ff);
   assign chan_ok   = int'(chan_ff) < CH;
   assign req_ready = (state_ff == rcca_pkg::S_IDLE);
   assign csr_ready = 1'b1;

   // take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 16'd8231;
         tick_ff <= 7'd2;
         min_ff  <= 12'd1100;
         max_ff  <= 12'd1900;
         rev_ff  <= 8'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            rcca_pkg::CSR_FILTER_GAIN:  gain_ff <= csr_wdata;
            rcca_pkg::CSR_TICK_MS:      tick_ff <= csr_wdata[6:0];
            rcca_pkg::CSR_MIN_STICK:    min_ff  <= csr_wdata[11:0];
            rcca_pkg::CSR_MAX_STICK:    max_ff  <= csr_wdata[11:0];
            rcca_pkg::CSR_REVERSE_MASK: rev_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // sequence one item through select, check, divide, multiply, finish
   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;  link_in = link_ff;  arm_in = arm_ff;  armt_in = armt_ff;
      held_in = held_ff;  fault_in = fault_ff; good_in = good_ff;
      norm_in = norm_ff;  filt_in = filt_ff;   prev_in = prev_ff; raw_in = raw_ff;
      op_in = op_ff; chan_in = chan_ff; rc_in = rc_ff; gs_in = gs_ff;
      last_in = last_ff; fm_in = fm_ff;
      s_in = s_ff; neg_in = neg_ff; wide_in = wide_ff;
      mcand_in = mcand_ff; acc_in = acc_ff; mplier_in = mplier_ff; mcnt_in = mcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_chan_in = o_chan_ff; o_stick_in = o_stick_ff; o_fv_in = o_fv_ff;
      o_chg_in = o_chg_ff; o_fault_in = o_fault_ff; o_arm_in = o_arm_ff;
      o_mode_in = o_mode_ff; o_cal_in = o_cal_ff;
      div_req = '0;
      samp = held_ff[idx];
      good_next = good_ff[idx] + 11'd1;
      fault_new = 1'b0;
      num_a = $signed({1'b0, s_ff}) - $signed({1'b0, min_ff});
      num = 25'(num_a) * 25'sd1000 - 25'($signed({1'b0, max_ff - min_ff})) * 25'sd500;
      num_mag = num[24] ? -num : num;
      qmag = (div_rsp.quotient > 23'd500) ? 10'd500 : div_rsp.quotient[9:0];
      qval = neg_ff ? -$signed(qmag) : $signed(qmag);
      err = (19'(norm_ff[idx]) <<< 8) - 19'(filt_ff[idx]);
      diff = (22'($signed({1'b0, s_ff})) <<< 8) - 22'(filt_ff[idx]);
      diff_mag = diff[21] ? -diff : diff;
      step = wide_ff ? (acc_ff >>> 17) : (acc_ff >>> 16);
      fsum = 35'(filt_ff[idx]) + step;
      fe_arm = arm_ff; fe_cal = 1'b0; fe_mode = mode_ff; fe_t = armt_ff;
      tsum = '0;
      lnext = {1'b0, link_ff} + 9'd1;

      unique case (state_ff)
         rcca_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in = req_operation; chan_in = req_channel;
               rc_in = req_rc_sample; gs_in = req_gs_sample;
               last_in = req_last_in_frame; fm_in = req_feed_mode;
               state_in = rcca_pkg::S_LOAD;
            end
         end
         rcca_pkg::S_LOAD: begin
            if (op_ff == rcca_pkg::OP_FEED || !chan_ok) begin
               state_in = rcca_pkg::S_DONE;
            end else begin
               // pick the source for this channel
               case (mode_ff)
                  rcca_pkg::MODE_RADIO:  samp = rc_ff;
                  rcca_pkg::MODE_GROUND: samp = gs_ff;
                  rcca_pkg::MODE_MIXED: begin
                     if (chan_ff == 3'd0 || chan_ff == 3'd1 || chan_ff == 3'd3) samp = gs_ff;
                     else if (chan_ff == 3'd2) samp = rc_ff;
                  end
                  default: ;
               endcase
               held_in[idx] = samp;
               s_in = samp;
               if (!chan_ff[2]) raw_in[chan_ff[1:0]] = rc_ff;
               // range check with recovery count
               fault_new = fault_ff[idx];
               if (samp > 12'd2500 || samp < 12'd500) begin
                  fault_new = 1'b1;
                  good_in[idx] = '0;
               end else if (good_next > 11'd200) begin
                  fault_new = 1'b0;
                  good_in[idx] = 11'd2000;
               end else begin
                  good_in[idx] = good_next;
               end
               fault_in[idx] = fault_new;
               state_in = rcca_pkg::S_FSETUP;
               if (mode_ff != rcca_pkg::MODE_LOST && !fault_new) begin
                  if (max_ff > min_ff) state_in = rcca_pkg::S_NUM;
                  else arm_in = 1'b0;
               end
            end
         end
         rcca_pkg::S_NUM: begin
            div_req.start    = 1'b1;
            div_req.dividend = num_mag[rcca_pkg::DIVIDEND_W-1:0];
            div_req.divisor  = max_ff - min_ff;
            neg_in = num[24];
            state_in = rcca_pkg::S_DIV;
         end
         rcca_pkg::S_DIV: begin
            if (div_rsp.done) begin
               norm_in[idx] = rev_ff[chan_ff] ? -qval : qval;
               state_in = rcca_pkg::S_FSETUP;
            end
         end
         rcca_pkg::S_FSETUP: begin
            mcand_in  = 35'(err);
            mplier_in = gain_ff;
            acc_in    = '0;
            mcnt_in   = '0;
            wide_in   = diff_mag >= 22'sd25600;
            state_in  = rcca_pkg::S_MUL;
         end
         rcca_pkg::S_MUL: begin
            // one gain bit per cycle
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            mcnt_in   = mcnt_ff + 4'd1;
            if (mcnt_ff == 4'd15) state_in = rcca_pkg::S_FILT;
         end
         rcca_pkg::S_FILT: begin
            if (fsum > 35'sd131071) filt_in[idx] = 18'sd131071;
            else if (fsum < -35'sd131072) filt_in[idx] = -18'sd131072;
            else filt_in[idx] = fsum[17:0];
            if (mode_ff == rcca_pkg::MODE_LOST && !arm_ff) filt_in[2] = rcca_pkg::FILT_FORCED;
            state_in = rcca_pkg::S_DONE;
         end
         rcca_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               o_chan_in = '0; o_stick_in = '0; o_fv_in = '0;
               o_chg_in = '0; o_fault_in = 1'b0;
               if (op_ff == rcca_pkg::OP_FEED) begin
                  if (mode_ff != rcca_pkg::MODE_MIXED) fe_mode = fm_ff;
                  link_in = '0;
               end else begin
                  if (chan_ok) begin
                     o_chan_in  = chan_ff;
                     o_stick_in = norm_ff[idx];
                     o_fv_in    = filt_ff[idx];
                     o_chg_in   = 19'(filt_ff[idx]) - 19'(prev_ff[idx]);
                     o_fault_in = fault_ff[idx];
                     prev_in[idx] = filt_ff[idx];
                  end
                  if (last_ff) begin
                     // arm and disarm stick holds
                     if (filt_ff[2] < rcca_pkg::FILT_ARM_LO) begin
                        if (filt_ff[3] < rcca_pkg::FILT_ARM_LO ||
                            (mode_ff == rcca_pkg::MODE_MIXED && raw_ff[3] < 12'd1100)) begin
                           if (fe_t != rcca_pkg::ARM_DONE && fe_arm) begin
                              tsum = 17'(fe_t) + 17'(11'(tick_ff) * 11'd10);
                              if (tsum > 17'd400) begin
                                 fe_arm = 1'b0; fe_t = rcca_pkg::ARM_DONE;
                              end else fe_t = tsum[15:0];
                           end
                           if (!fe_arm) begin
                              if (raw_ff[0] > 12'd1900 && raw_ff[1] > 12'd1900)
                                 fe_mode = rcca_pkg::MODE_MIXED;
                              else if (raw_ff[1] > 12'd1900 && raw_ff[0] < 12'd1100)
                                 fe_mode = rcca_pkg::MODE_RADIO;
                           end
                        end else if (filt_ff[3] > rcca_pkg::FILT_ARM_HI ||
                                     (mode_ff == rcca_pkg::MODE_MIXED && raw_ff[3] > 12'd1900)) begin
                           if (fe_t != rcca_pkg::ARM_DONE && !fe_arm) begin
                              tsum = 17'(fe_t) + 17'(tick_ff);
                              if (tsum > 17'd1500) begin
                                 fe_arm = 1'b1; fe_t = rcca_pkg::ARM_DONE; fe_cal = 1'b1;
                              end else fe_t = tsum[15:0];
                           end
                        end else if (fe_t == rcca_pkg::ARM_DONE) begin
                           fe_t = '0;
                        end
                     end else begin
                        fe_t = '0;
                     end
                     // age the link watchdog
                     if (lnext > 9'd200) begin
                        link_in = '0; fe_mode = rcca_pkg::MODE_LOST;
                     end else link_in = lnext[7:0];
                  end
               end
               mode_in = fe_mode; arm_in = fe_arm; armt_in = fe_t;
               o_arm_in = fe_arm; o_mode_in = fe_mode; o_cal_in = fe_cal;
               rsp_valid_in = 1'b1;
               state_in = rcca_pkg::S_IDLE;
            end
         end
         default: state_in = rcca_pkg::S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= rcca_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   // block and channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rcca_pkg::MODE_RADIO;
         link_ff <= '0; arm_ff <= 1'b0; armt_ff <= '0; rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CH; i++) begin
            held_ff[i] <= '0; fault_ff[i] <= 1'b0; good_ff[i] <= '0;
            norm_ff[i] <= '0; filt_ff[i] <= '0; prev_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) raw_ff[i] <= '0;
      end else begin
         mode_ff <= mode_in; link_ff <= link_in; arm_ff <= arm_in; armt_ff <= armt_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff <= held_in; fault_ff <= fault_in; good_ff <= good_in;
         norm_ff <= norm_in; filt_ff <= filt_in; prev_ff <= prev_in; raw_ff <= raw_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      op_ff <= op_in; chan_ff <= chan_in; rc_ff <= rc_in; gs_ff <= gs_in;
      last_ff <= last_in; fm_ff <= fm_in;
      s_ff <= s_in; neg_ff <= neg_in; wide_ff <= wide_in;
      mcand_ff <= mcand_in; acc_ff <= acc_in; mplier_ff <= mplier_in; mcnt_ff <= mcnt_in;
      o_chan_ff <= o_chan_in; o_stick_ff <= o_stick_in; o_fv_ff <= o_fv_in;
      o_chg_ff <= o_chg_in; o_fault_ff <= o_fault_in; o_arm_ff <= o_arm_in;
      o_mode_ff <= o_mode_in; o_cal_ff <= o_cal_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_channel_out       = o_chan_ff;
   assign rsp_stick_value       = o_stick_ff;
   assign rsp_filtered_value    = o_fv_ff;
   assign rsp_filtered_change   = o_chg_ff;
   assign rsp_channel_fault     = o_fault_ff;
   assign rsp_armed             = o_arm_ff;
   assign rsp_link_mode         = o_mode_ff;
   assign rsp_link_lost         = (o_mode_ff == rcca_pkg::MODE_LOST);
   assign rsp_calibrate_request = o_cal_ff;

   a_cal_armed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_cal_ff) |-> o_arm_ff)
      else $error("calibrate request without armed");
   a_stick_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (o_stick_ff <= 10'sd500 && o_stick_ff >= -10'sd500))
      else $error("stick value out of range");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == rcca_pkg::S_DIV)
      else $error("divider finished outside divide step");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == rcca_pkg::S_DONE)
      else $error("result raised outside finish step");

endmodule
